### hdl/dfs_pkg.sv
// Package for the depth-first topological sort block.
// Holds the request/result structs, command codes and default sizes; no dependencies.
package dfs_pkg;

  localparam int unsigned DefMaxVertices = 64;
  localparam int unsigned DefMaxEdges    = 256;
  localparam int unsigned VtxW           = 6;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SORT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [VtxW-1:0] from_vertex;
    logic [VtxW-1:0] to_vertex;
    logic            both_ways;
  } in_req_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            last;
    logic            empty_graph;
    logic            overflow;
  } out_res_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ADD_FWD,
    OP_ADD_REV,
    OP_CLEAR,
    OP_SORT_INIT,
    OP_SCAN,
    OP_TOP_RD,
    OP_STEP,
    OP_EDGE_RD,
    OP_FOLLOW,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic scan_done;   // root scan passed the last vertex
    logic root_ok;     // current scan vertex starts a walk
    logic stack_empty; // walk depth is zero
    logic frame_done;  // top frame has no edges left
    logic emit_done;   // an emit this cycle sends the final result
  } dp_status_t;

endpackage

### hdl/dfs_datapath.sv
// Datapath of the sort block: edge store, vertex lists, walk stack, postorder.
// Depends on dfs_pkg; sequenced by dfs_ctrl.
module dfs_datapath
  import dfs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DefMaxVertices,
  parameter int unsigned MAX_EDGES    = DefMaxEdges
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_op_t     op,
  input  in_req_t    req,
  output dp_status_t status,
  output logic       out_valid,
  output out_res_t   out_result
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);   // holds null link
  localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam logic [EW-1:0] ENull = EW'(MAX_EDGES);

  logic [VW-1:0] edge_target [MAX_EDGES];
  logic [EW-1:0] edge_next   [MAX_EDGES];
  logic [EW-1:0] list_head   [MAX_VERTICES];
  logic [EA-1:0] list_tail   [MAX_VERTICES];
  logic [VW-1:0] stk_vtx     [MAX_VERTICES];
  logic [EW-1:0] stk_edge    [MAX_VERTICES];
  logic [VW-1:0] post_order  [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] has_out_r, seen_r;
  logic [EW-1:0] edge_count_r;
  logic          dropped_r;
  logic [CW-1:0] depth_r, count_r, emit_r;
  logic [CW-1:0] scan_r;
  logic [VW-1:0] top_vtx_r, tgt_r;
  logic [EW-1:0] top_edge_r, nxt_r;
  logic          out_valid_r;
  logic [VW-1:0] out_vtx_r;
  logic          out_last_r, out_empty_r, out_ovf_r;
  logic [EA-1:0] tail_rd_r;
  logic          link_pend_r;
  logic [EW-1:0] link_edge_r;

  logic [31:0] src_w, dst_w;
  logic        in_range;
  logic        add_ok;
  logic [VW-1:0] src, dst, scan_v;
  logic [CW-1:0] top_idx;

  // Input ids may exceed the vertex count when it is smaller than 64.
  assign src_w    = 32'(op == OP_ADD_REV ? req.to_vertex : req.from_vertex);
  assign dst_w    = 32'(op == OP_ADD_REV ? req.from_vertex : req.to_vertex);
  assign in_range = (32'(req.from_vertex) < MAX_VERTICES) &&
                    (32'(req.to_vertex) < MAX_VERTICES);
  assign add_ok   = (op == OP_ADD_FWD || op == OP_ADD_REV) && in_range &&
                    (32'(edge_count_r) < MAX_EDGES);
  assign src      = src_w[VW-1:0];
  assign dst      = dst_w[VW-1:0];
  assign scan_v   = scan_r[VW-1:0];
  assign top_idx  = depth_r - CW'(1);

  assign status.scan_done   = (32'(scan_r) >= MAX_VERTICES);
  assign status.root_ok     = (32'(scan_r) < MAX_VERTICES) && has_out_r[scan_v]
                              && !seen_r[scan_v];
  assign status.stack_empty = (depth_r == '0);
  assign status.frame_done  = (32'(top_edge_r) >= MAX_EDGES);
  assign status.emit_done   = (count_r == '0) || (emit_r + CW'(1) == count_r);

  // Memories: edge store, list links, stack and postorder.
  always_ff @(posedge clk) begin
    if (add_ok) begin
      edge_target[edge_count_r[EA-1:0]] <= dst;
      edge_next[edge_count_r[EA-1:0]]   <= ENull;
      if (!has_out_r[src]) list_head[src] <= edge_count_r;
      list_tail[src] <= edge_count_r[EA-1:0];
      tail_rd_r      <= list_tail[src];
    end
    // Chain the previous tail to the new edge in the cycle after the add.
    if (link_pend_r) edge_next[tail_rd_r] <= link_edge_r;
    if (op == OP_EDGE_RD) begin
      tgt_r <= edge_target[top_edge_r[EA-1:0]];
      nxt_r <= edge_next[top_edge_r[EA-1:0]];
    end
    if (op == OP_TOP_RD && depth_r != '0) begin
      top_vtx_r  <= stk_vtx[top_idx[VW-1:0]];
      top_edge_r <= stk_edge[top_idx[VW-1:0]];
    end
    if (op == OP_SCAN && status.root_ok) begin
      stk_vtx[0]  <= scan_v;
      stk_edge[0] <= list_head[scan_v];
    end
    if (op == OP_STEP && status.frame_done && 32'(count_r) < MAX_VERTICES)
      post_order[count_r[VW-1:0]] <= top_vtx_r;
    if (op == OP_FOLLOW) begin
      // Save advanced link of the current frame, then maybe push.
      stk_edge[top_idx[VW-1:0]] <= nxt_r;
      if (!seen_r[tgt_r] && 32'(depth_r) < MAX_VERTICES) begin
        stk_vtx[depth_r[VW-1:0]]  <= tgt_r;
        stk_edge[depth_r[VW-1:0]] <= has_out_r[tgt_r] ? list_head[tgt_r] : ENull;
      end
    end
    // Empty-graph result carries vertex zero.
    if (op == OP_EMIT)
      out_vtx_r <= (count_r == '0) ? '0 : post_order[VW'(count_r - emit_r - CW'(1))];
  end

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_out_r    <= '0;
      seen_r       <= '0;
      edge_count_r <= '0;
      dropped_r    <= 1'b0;
      depth_r      <= '0;
      count_r      <= '0;
      emit_r       <= '0;
      scan_r       <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      out_empty_r  <= 1'b0;
      out_ovf_r    <= 1'b0;
      link_pend_r  <= 1'b0;
      link_edge_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      link_pend_r <= add_ok && has_out_r[src];
      link_edge_r <= edge_count_r;
      unique case (op)
        OP_ADD_FWD, OP_ADD_REV: begin
          if (in_range) begin
            if (32'(edge_count_r) < MAX_EDGES) begin
              edge_count_r   <= edge_count_r + EW'(1);
              has_out_r[src] <= 1'b1;
            end else begin
              dropped_r <= 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          has_out_r    <= '0;
          edge_count_r <= '0;
        end
        OP_SORT_INIT: begin
          seen_r  <= '0;
          depth_r <= '0;
          count_r <= '0;
          emit_r  <= '0;
          scan_r  <= '0;
        end
        OP_SCAN: begin
          if (status.root_ok) begin
            seen_r[scan_v] <= 1'b1;
            depth_r        <= CW'(1);
          end
          scan_r <= scan_r + CW'(1);
        end
        OP_STEP: begin
          if (status.frame_done) begin
            if (32'(count_r) < MAX_VERTICES) count_r <= count_r + CW'(1);
            depth_r <= depth_r - CW'(1);
          end
        end
        OP_FOLLOW: begin
          if (!seen_r[tgt_r] && 32'(depth_r) < MAX_VERTICES) begin
            seen_r[tgt_r] <= 1'b1;
            depth_r       <= depth_r + CW'(1);
          end
        end
        OP_EMIT: begin
          out_valid_r <= 1'b1;
          out_ovf_r   <= dropped_r;
          if (count_r == '0) begin
            out_last_r  <= 1'b1;
            out_empty_r <= 1'b1;
            emit_r      <= CW'(1);
            count_r     <= CW'(1);
          end else begin
            out_last_r  <= (emit_r + CW'(1) == count_r);
            out_empty_r <= 1'b0;
            emit_r      <= emit_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  always_comb begin
    out_result.vertex      = VtxW'(out_vtx_r);
    out_result.last        = out_last_r;
    out_result.empty_graph = out_empty_r;
    out_result.overflow    = out_ovf_r;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= MAX_VERTICES) else $error("walk depth out of range");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(edge_count_r) <= MAX_EDGES) else $error("edge count out of range");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= count_r || count_r == '0) else $error("emit past postorder end");

endmodule

### hdl/dfs_ctrl.sv
// Controller of the sort block: sequences adds, clears, the walk and the emit.
// Depends on dfs_pkg; drives dfs_datapath.
module dfs_ctrl
  import dfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_req_t    in_req,
  input  dp_status_t status,
  output logic       busy,
  output dp_op_t     op,
  output in_req_t    req
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_REV, S_INIT, S_SCAN, S_TOP, S_STEP, S_ERD, S_FOLLOW, S_EMIT
  } state_t;

  state_t  state_r;
  in_req_t req_r;

  assign busy = (state_r != S_IDLE);
  assign req  = (state_r == S_IDLE) ? in_req : req_r;

  always_comb begin
    op = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_req.command))
            CMD_ADD:   op = OP_ADD_FWD;
            CMD_CLEAR: op = OP_CLEAR;
            CMD_SORT:  op = OP_SORT_INIT;
            default:   op = OP_IDLE;
          endcase
        end
      end
      S_ADD_REV: op = OP_ADD_REV;
      S_INIT:    op = OP_IDLE;
      S_SCAN:    op = OP_SCAN;
      S_TOP:     op = OP_TOP_RD;
      S_STEP:    op = OP_STEP;
      S_ERD:     op = OP_EDGE_RD;
      S_FOLLOW:  op = OP_FOLLOW;
      S_EMIT:    op = OP_EMIT;
      default:   op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r <= in_req;
            if (cmd_t'(in_req.command) == CMD_ADD && in_req.both_ways)
              state_r <= S_ADD_REV;
            else if (cmd_t'(in_req.command) == CMD_SORT)
              state_r <= S_SCAN;
          end
        end
        S_ADD_REV: state_r <= S_IDLE;
        S_INIT:    state_r <= S_SCAN;
        S_SCAN: begin
          if (status.scan_done)    state_r <= S_EMIT;
          else if (status.root_ok) state_r <= S_TOP;
        end
        S_TOP: state_r <= status.stack_empty ? S_SCAN : S_STEP;
        S_STEP: state_r <= status.frame_done ? S_TOP : S_ERD;
        S_ERD:  state_r <= S_FOLLOW;
        S_FOLLOW: state_r <= S_TOP;
        S_EMIT: if (status.emit_done || status.scan_done == 1'b0) state_r <= S_IDLE;
                else state_r <= S_EMIT;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_rev_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD_REV |-> $past(state_r) == S_IDLE) else $error("bad reverse add");
  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && $past(state_r) != S_EMIT) |-> $past(status.scan_done))
    else $error("emit before scan end");
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (busy == (state_r != S_IDLE)))
    else $error("busy mismatch");

endmodule

### hdl/dfs_topological_sort.sv
// Top level of the depth-first topological sort block.
// Depends on dfs_pkg; instantiates dfs_ctrl and dfs_datapath.
//
//  channel | ports                          | handshake
//  request | start, busy, in_req            | taken when start && !busy
//  result  | out_valid, out_result          | one-cycle strobe, no backpressure
//
// Add edge: stores the edge; with both_ways set, a second step stores the reverse.
// Clear: empties the graph. Sort: a start step, a root scan over all vertices, then
//   per followed edge a stack read, frame check, edge-store read and follow, per
//   finished vertex a stack read and frame check, per walk root a stack read that sees
//   the stack empty, then the emit: one result per cycle (a single result for an empty graph).
// Reset is synchronous, active low; it empties the graph and clears overflow.
// The receiver cannot stall; results leave at one per cycle.
module dfs_topological_sort
  import dfs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DefMaxVertices,
  parameter int unsigned MAX_EDGES    = DefMaxEdges
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_result
);

  dp_op_t     op;
  dp_status_t status;
  in_req_t    req;

  // Sequence every request through the controller.
  dfs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_req),
    .status (status),
    .busy   (busy),
    .op     (op),
    .req    (req)
  );

  // Hold graph, walk stack and postorder.
  dfs_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .req        (req),
    .status     (status),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

### tb/dfs_topological_sort_test.sv
// Self-checking bench for dfs_topological_sort: a start/busy request driver, a result monitor
// and a predictor of edge storage and the depth-first reverse postorder.
// Depends on dfs_pkg and the dfs_topological_sort RTL.
module dfs_topological_sort_test;
  import dfs_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int LIMIT = 2000000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_res_t out_result;

  dfs_topological_sort dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  // Predicted graph: per-vertex out-edge lists in insertion order.
  int  adj[NV][$];
  int  stored_edges;
  bit  dropped;
  out_res_t order_q[$];
  in_req_t  pending_q[$];

  int  mismatches;
  int  cycles;
  int  send_idle_pct;
  bit  hold_for_drain;
  bit  done_feeding;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void queue_req(in_req_t q);
    pending_q = {pending_q, q};
  endfunction

  function automatic void store_edge(int src, int dst);
    if (stored_edges >= NE) begin
      dropped = 1'b1;
    end else begin
      stored_edges++;
      adj[src] = {adj[src], dst};
    end
  endfunction

  // Walk the graph with an explicit stack and queue the reverse postorder.
  function automatic void predict_order();
    bit seen[NV];
    int stk_v[NV];
    int stk_i[NV];
    int post[$];
    int depth;
    int t;
    out_res_t r;
    for (int s = 0; s < NV; s++) begin
      if (adj[s].size() == 0 || seen[s]) continue;
      seen[s] = 1'b1;
      stk_v[0] = s;
      stk_i[0] = 0;
      depth = 1;
      while (depth > 0) begin
        if (stk_i[depth-1] >= adj[stk_v[depth-1]].size()) begin
          post = {post, stk_v[depth-1]};
          depth--;
        end else begin
          t = adj[stk_v[depth-1]][stk_i[depth-1]];
          stk_i[depth-1]++;
          if (!seen[t] && depth < NV) begin
            seen[t] = 1'b1;
            stk_v[depth] = t;
            stk_i[depth] = 0;
            depth++;
          end
        end
      end
    end
    if (post.size() == 0) begin
      r = '{vertex: '0, last: 1'b1, empty_graph: 1'b1, overflow: dropped};
      order_q = {order_q, r};
    end else begin
      for (int k = post.size() - 1; k >= 0; k--) begin
        r = '{vertex: post[k][5:0], last: (k == 0), empty_graph: 1'b0, overflow: dropped};
        order_q = {order_q, r};
      end
    end
  endfunction

  function automatic void predict_request(in_req_t q);
    case (q.command)
      CMD_ADD: begin
        store_edge(q.from_vertex, q.to_vertex);
        if (q.both_ways) store_edge(q.to_vertex, q.from_vertex);
      end
      CMD_SORT: predict_order();
      CMD_CLEAR: begin
        for (int i = 0; i < NV; i++) adj[i].delete();
        stored_edges = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic in_req_t mk(cmd_t c, int f, int t, bit b);
    in_req_t q;
    q.command = c;
    q.from_vertex = f[5:0];
    q.to_vertex = t[5:0];
    q.both_ways = b;
    return q;
  endfunction

  // Driver: hold a request until accepted, then advance or idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
    end else if (!(start && busy)) begin
      if (start) predict_request(in_req);
      if (pending_q.size() != 0 && !(hold_for_drain && (order_q.size() != 0 || start))
          && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        in_req <= pending_q.pop_front();
      end else begin
        start <= 1'b0;
        in_req <= mk(cmd_t'($urandom_range(3)), $urandom, $urandom, $urandom);
      end
    end
  end

  // Monitor: compare each result strobe against the oldest predicted vertex.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (order_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", out_result);
      end else begin
        if (out_result !== order_q[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p got %p", order_q[0], out_result);
        end
        void'(order_q.pop_front());
      end
    end
  end

  task automatic add_random_graph(int nv, int ne);
    int b;
    b = $urandom_range(NV - nv);
    repeat (ne)
      queue_req(mk(CMD_ADD, b + $urandom_range(nv - 1), b + $urandom_range(nv - 1),
                   $urandom_range(3) == 0));
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || start || order_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    mismatches = 0;
    cycles = 0;
    stored_edges = 0;
    dropped = 1'b0;
    send_idle_pct = 13;
    hold_for_drain = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty sort, extremes, self loop, both-ways, unused command, clear.
    queue_req(mk(CMD_SORT, 0, 0, 0));
    queue_req(mk(CMD_ADD, 63, 0, 0));
    queue_req(mk(CMD_ADD, 0, 63, 1));
    queue_req(mk(CMD_ADD, 5, 5, 0));
    queue_req(mk(CMD_ADD, 42, 21, 1));
    queue_req(mk(CMD_NOP, 63, 63, 1));
    queue_req(mk(CMD_SORT, 63, 63, 1));
    queue_req(mk(CMD_CLEAR, 0, 0, 0));
    queue_req(mk(CMD_SORT, 0, 0, 0));
    queue_req(mk(CMD_ADD, 1, 2, 0));
    queue_req(mk(CMD_ADD, 2, 3, 0));
    queue_req(mk(CMD_ADD, 1, 3, 0));
    queue_req(mk(CMD_SORT, 0, 0, 0));
    queue_req(mk(CMD_CLEAR, 0, 0, 0));
    wait_drained();

    // Fill the store past capacity to raise the sticky overflow flag.
    hold_for_drain = 1'b1;
    for (int i = 0; i < 130; i++)
      queue_req(mk(CMD_ADD, i % 64, (i * 7 + 3) % 64, 1'b1));
    queue_req(mk(CMD_SORT, 0, 0, 0));
    queue_req(mk(CMD_CLEAR, 0, 0, 0));
    queue_req(mk(CMD_SORT, 0, 0, 0));
    wait_drained();
    hold_for_drain = 1'b0;

    // Random graphs, mostly small, each ended by a sort; then idle pattern swaps.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 71 : 0;
      for (int g = 0; g < 8; g++) begin
        if ($urandom_range(9) == 0) add_random_graph(64, $urandom_range(20, 40));
        else add_random_graph($urandom_range(1, 12), $urandom_range(0, 10));
        if ($urandom_range(7) == 0)
          queue_req(mk(cmd_t'($urandom_range(3)), $urandom, $urandom, $urandom));
        queue_req(mk(CMD_SORT, $urandom, $urandom, $urandom));
        if ($urandom_range(2) != 0) queue_req(mk(CMD_CLEAR, $urandom, $urandom, 0));
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && order_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog on the cycle counter.
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

### sim.f
hdl/dfs_pkg.sv
hdl/dfs_datapath.sv
hdl/dfs_ctrl.sv
hdl/dfs_topological_sort.sv
tb/dfs_topological_sort_test.sv
